// File: src/serial_frame_deframer_sum16_macros.svh
// ----------------------------------------------------------------------------
// Serial frame deframer assertion macros
// Shared property wrappers for the deframer checker.
// ----------------------------------------------------------------------------
`ifndef SERIAL_FRAME_DEFRAMER_SUM16_MACROS_SVH
`define SERIAL_FRAME_DEFRAMER_SUM16_MACROS_SVH

// Same-cycle implication, disabled during reset
`define SFD_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset
`define SFD_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: src/sfd_pkg.sv
// ----------------------------------------------------------------------------
// Serial frame deframer package
// Result kinds, register indexes, reset values and the command format.
// ----------------------------------------------------------------------------
package sfd_pkg;

  // Result kind codes
  typedef enum logic [2:0] {
    KIND_BYTE     = 3'd0,
    KIND_EMPTY    = 3'd1,
    KIND_SUM_ERR  = 3'd2,
    KIND_TIMEOUT  = 3'd3,
    KIND_OVERFLOW = 3'd4
  } kind_t;

  // Input action codes
  localparam logic ACT_BYTE = 1'b0;
  localparam logic ACT_TICK = 1'b1;

  // Configuration register indexes
  localparam int unsigned CFG_IDX_W = 4;
  localparam logic [CFG_IDX_W-1:0] CFG_CHECKSUM_ENABLE = 4'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT_TICKS   = 4'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_HEAD_BYTE       = 4'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_TRAILER_WORD    = 4'd3;

  // Register reset values
  localparam logic        RST_CHECKSUM_ENABLE = 1'b1;
  localparam logic [7:0]  RST_TIMEOUT_TICKS   = 8'd10;
  localparam logic [7:0]  RST_HEAD_BYTE       = 8'hAA;
  localparam logic [31:0] RST_TRAILER_WORD    = 32'hCC33_C33C;

  // Frame layout
  localparam int unsigned TRAILER_BYTES  = 4;
  localparam int unsigned SUM_FRAME_MIN  = 6;
  localparam int unsigned FL_W           = 5;

  // Command from front to back, besides the run length
  typedef struct packed {
    kind_t           kind;
    logic [FL_W-1:0] frame_length;
  } cmd_t;

endpackage

// File: src/sfd_front.sv
// ----------------------------------------------------------------------------
// Deframer front end
// Holds configuration, tracks frame state, stores bytes and issues commands.
// ----------------------------------------------------------------------------
module sfd_front
  import sfd_pkg::*;
#(
  parameter int unsigned BUFFER_BYTES = 32
) (
  input  logic                              clk,
  input  logic                              rst,
  // configuration writes
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [CFG_IDX_W-1:0]              cfg_index,
  input  logic [31:0]                       cfg_data,
  // input items
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic                              action,
  input  logic [7:0]                        rx_byte,
  // frame store write port
  output logic                              wr_en,
  output logic [$clog2(BUFFER_BYTES)-1:0]   wr_addr,
  output logic [7:0]                        wr_data,
  // command queue
  output logic                              q_push,
  output cmd_t                              q_cmd,
  output logic [$clog2(BUFFER_BYTES+1)-1:0] q_len,
  input  logic                              q_ready,
  input  logic                              run_done
);

  localparam int unsigned ADDR_W = $clog2(BUFFER_BYTES);
  localparam int unsigned CNT_W  = $clog2(BUFFER_BYTES + 1);

  // configuration registers
  logic        checksum_enable;
  logic [7:0]  timeout_ticks;
  logic [7:0]  head_byte;
  logic [31:0] trailer_word;

  // frame state
  logic              in_frame, in_frame_next;
  logic [CNT_W-1:0]  count, count_next;
  logic [7:0]        tick_count, tick_count_next;
  logic [47:0]       tail, tail_next;
  logic [15:0]       sum, sum_next;
  logic              run_busy;

  logic             take;
  logic [CNT_W-1:0] count_inc;
  logic [CNT_W-1:0] n_sum;
  logic [CNT_W-1:0] n_plain;
  logic [47:0]      tail_shift;
  logic [15:0]      sum_add;
  logic [7:0]       tick_inc;
  logic             trailer_hit;

  assign cfg_ready = 1'b1;
  assign in_stall  = run_busy || !q_ready;
  assign take      = in_valid && !in_stall;

  // write configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      checksum_enable <= RST_CHECKSUM_ENABLE;
      timeout_ticks   <= RST_TIMEOUT_TICKS;
      head_byte       <= RST_HEAD_BYTE;
      trailer_word    <= RST_TRAILER_WORD;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_CHECKSUM_ENABLE: checksum_enable <= cfg_data[0];
        CFG_TIMEOUT_TICKS:   timeout_ticks   <= cfg_data[7:0];
        CFG_HEAD_BYTE:       head_byte       <= cfg_data[7:0];
        CFG_TRAILER_WORD:    trailer_word    <= cfg_data;
        default: ;
      endcase
    end
  end

  // candidate values for a stored byte or a tick
  assign count_inc   = count + CNT_W'(1);
  assign n_sum       = count_inc - CNT_W'(SUM_FRAME_MIN);
  assign n_plain     = count_inc - CNT_W'(TRAILER_BYTES);
  assign tail_shift  = {tail[39:0], rx_byte};
  assign sum_add     = sum + {8'h00, tail[47:40]};
  assign tick_inc    = tick_count + 8'd1;
  assign trailer_hit = (count_inc >= CNT_W'(TRAILER_BYTES)) &&
                       (tail_shift[31:0] == trailer_word);

  // classify the accepted item
  always_comb begin
    in_frame_next   = in_frame;
    count_next      = count;
    tick_count_next = tick_count;
    tail_next       = tail;
    sum_next        = sum;
    wr_en           = 1'b0;
    wr_addr         = count[ADDR_W-1:0];
    wr_data         = rx_byte;
    q_push          = 1'b0;
    q_cmd.kind         = KIND_BYTE;
    q_cmd.frame_length = '0;
    q_len           = '0;

    if (take) begin
      if (action == ACT_TICK) begin
        if (!in_frame) begin
          tick_count_next = 8'd0;
        end else begin
          tick_count_next = tick_inc;
          if (tick_inc >= timeout_ticks) begin
            q_push          = 1'b1;
            q_cmd.kind      = KIND_TIMEOUT;
            in_frame_next   = 1'b0;
            count_next      = '0;
            tick_count_next = 8'd0;
          end
        end
      end else if (!in_frame) begin
        // open a frame on the head byte
        if (rx_byte == head_byte) begin
          in_frame_next   = 1'b1;
          count_next      = '0;
          tick_count_next = 8'd0;
          sum_next        = 16'd0;
        end
      end else if (count == CNT_W'(BUFFER_BYTES)) begin
        // drop the byte and abort on overflow
        q_push          = 1'b1;
        q_cmd.kind      = KIND_OVERFLOW;
        in_frame_next   = 1'b0;
        count_next      = '0;
        tick_count_next = 8'd0;
      end else begin
        wr_en      = 1'b1;
        count_next = count_inc;
        tail_next  = tail_shift;
        if (count >= CNT_W'(SUM_FRAME_MIN)) begin
          sum_next = sum_add;
        end
        if (trailer_hit) begin
          q_push          = 1'b1;
          in_frame_next   = 1'b0;
          count_next      = '0;
          tick_count_next = 8'd0;
          if (checksum_enable) begin
            if (count_inc < CNT_W'(SUM_FRAME_MIN)) begin
              q_cmd.kind = KIND_SUM_ERR;
            end else if (sum_next != tail_shift[47:32]) begin
              q_cmd.kind         = KIND_SUM_ERR;
              q_cmd.frame_length = FL_W'(n_sum);
            end else if (n_sum == '0) begin
              q_cmd.kind = KIND_EMPTY;
            end else begin
              q_cmd.kind         = KIND_BYTE;
              q_cmd.frame_length = FL_W'(n_sum);
              q_len              = n_sum;
            end
          end else if (n_plain == '0) begin
            q_cmd.kind = KIND_EMPTY;
          end else begin
            q_cmd.kind         = KIND_BYTE;
            q_cmd.frame_length = FL_W'(n_plain);
            q_len              = n_plain;
          end
        end
      end
    end
  end

  // hold frame state
  always_ff @(posedge clk) begin
    if (rst) begin
      in_frame   <= 1'b0;
      count      <= '0;
      tick_count <= 8'd0;
      run_busy   <= 1'b0;
    end else begin
      in_frame   <= in_frame_next;
      count      <= count_next;
      tick_count <= tick_count_next;
      if (q_push && q_cmd.kind == KIND_BYTE) begin
        run_busy <= 1'b1;
      end else if (run_done) begin
        run_busy <= 1'b0;
      end
    end
  end

  // payload history: last six bytes and sum of older ones
  always_ff @(posedge clk) begin
    tail <= tail_next;
    sum  <= sum_next;
  end

endmodule

// File: src/sfd_fifo.sv
// ----------------------------------------------------------------------------
// Deframer command queue
// Small first-in first-out buffer between the front and back ends.
// ----------------------------------------------------------------------------
module sfd_fifo #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  output logic             ready,
  output logic             valid,
  input  logic             pop,
  output logic [WIDTH-1:0] pop_data
);

  localparam int unsigned PTR_W = $clog2(DEPTH);
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] entries [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] fill;
  logic             do_push;
  logic             do_pop;

  assign ready    = (fill != CNT_W'(DEPTH));
  assign valid    = (fill != '0);
  assign do_push  = push && ready;
  assign do_pop   = pop && valid;
  assign pop_data = entries[rd_ptr];

  // store entries
  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  // advance pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      case ({do_push, do_pop})
        2'b10:   fill <= fill + CNT_W'(1);
        2'b01:   fill <= fill - CNT_W'(1);
        default: fill <= fill;
      endcase
    end
  end

endmodule

// File: src/sfd_back.sv
// ----------------------------------------------------------------------------
// Deframer back end
// Owns the frame store and turns queued commands into result transactions.
// ----------------------------------------------------------------------------
module sfd_back
  import sfd_pkg::*;
#(
  parameter int unsigned BUFFER_BYTES = 32
) (
  input  logic                              clk,
  input  logic                              rst,
  // frame store write port
  input  logic                              wr_en,
  input  logic [$clog2(BUFFER_BYTES)-1:0]   wr_addr,
  input  logic [7:0]                        wr_data,
  // command queue
  input  logic                              q_valid,
  input  cmd_t                              q_cmd,
  input  logic [$clog2(BUFFER_BYTES+1)-1:0] q_len,
  output logic                              q_pop,
  output logic                              run_done,
  // result channel
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [2:0]                        kind,
  output logic [7:0]                        payload_byte,
  output logic                              last,
  output logic [FL_W-1:0]                   frame_length
);

  localparam int unsigned ADDR_W = $clog2(BUFFER_BYTES);
  localparam int unsigned CNT_W  = $clog2(BUFFER_BYTES + 1);

  typedef enum logic [1:0] {
    S_IDLE,
    S_READ,
    S_SHOW
  } state_t;

  logic [7:0]       store [BUFFER_BYTES];
  state_t           state;
  logic [ADDR_W-1:0] idx;
  logic [CNT_W-1:0] run_len;
  logic [FL_W-1:0]  run_fl;
  logic             is_run;
  kind_t            out_kind;
  logic [7:0]       out_byte;
  logic             out_last;
  logic [FL_W-1:0]  out_len;
  logic             out_take;

  assign q_pop        = (state == S_IDLE) && q_valid;
  assign out_valid    = (state == S_SHOW);
  assign out_take     = out_valid && !out_stall;
  assign run_done     = out_take && is_run && out_last;
  assign kind         = out_kind;
  assign payload_byte = out_byte;
  assign last         = out_last;
  assign frame_length = out_len;

  // write the frame store
  always_ff @(posedge clk) begin
    if (wr_en) begin
      store[wr_addr] <= wr_data;
    end
  end

  // walk commands and hold the result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      case (state)
        S_IDLE: begin
          if (q_valid) begin
            idx     <= '0;
            run_len <= q_len;
            run_fl  <= q_cmd.frame_length;
            if (q_cmd.kind == KIND_BYTE) begin
              is_run <= 1'b1;
              state  <= S_READ;
            end else begin
              is_run   <= 1'b0;
              out_kind <= q_cmd.kind;
              out_byte <= 8'h00;
              out_last <= 1'b1;
              out_len  <= q_cmd.frame_length;
              state    <= S_SHOW;
            end
          end
        end
        S_READ: begin
          out_kind <= KIND_BYTE;
          out_byte <= store[idx];
          out_last <= (CNT_W'(idx) == CNT_W'(run_len - CNT_W'(1)));
          out_len  <= run_fl;
          state    <= S_SHOW;
        end
        S_SHOW: begin
          if (!out_stall) begin
            if (is_run && !out_last) begin
              idx   <= idx + ADDR_W'(1);
              state <= S_READ;
            end else begin
              state <= S_IDLE;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// File: src/serial_frame_deframer_sum16.sv
// ----------------------------------------------------------------------------
// Serial frame deframer with a 16-bit payload sum
// Input channel (in_valid/in_stall): one transaction per received UART byte
// (action 0, rx_byte) or timer tick (action 1). A head byte opens a frame,
// later bytes are stored until the last four match the trailer word.
// Result channel (out_valid/out_stall): a good frame yields its payload as a
// run of kind-0 transactions, last set on the final byte; an empty frame,
// checksum error, timeout or overflow yields a single transaction with last.
// Configuration channel (cfg_valid/cfg_ready): register writes, always ready.
// With the back end idle, a single result passes through the command queue
// and then the result register. A payload run passes through the command
// queue, then each byte goes through a frame store read and then the result
// register before the next byte is read.
// Input is stalled while a payload run is being read out of the frame store
// and while the 2-entry command queue is full; error results queue behind.
// Receiver stall holds the result register and pauses the store walk.
// Synchronous reset clears frame state and restores register defaults; the
// frame store has no clearing pass and is only read where written.
// ----------------------------------------------------------------------------
module serial_frame_deframer_sum16
  import sfd_pkg::*;
#(
  parameter int unsigned BUFFER_BYTES = 32
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]          cfg_data,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic                 action,
  input  logic [7:0]           rx_byte,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [2:0]           kind,
  output logic [7:0]           payload_byte,
  output logic                 last,
  output logic [FL_W-1:0]      frame_length
);

  localparam int unsigned ADDR_W = $clog2(BUFFER_BYTES);
  localparam int unsigned CNT_W  = $clog2(BUFFER_BYTES + 1);
  localparam int unsigned CMD_W  = $bits(cmd_t);
  localparam int unsigned Q_W    = CMD_W + CNT_W;

  logic              wr_en;
  logic [ADDR_W-1:0] wr_addr;
  logic [7:0]        wr_data;
  logic              q_push;
  cmd_t              push_cmd;
  logic [CNT_W-1:0]  push_len;
  logic              q_ready;
  logic              q_valid;
  logic              q_pop;
  logic [Q_W-1:0]    q_head;
  cmd_t              pop_cmd;
  logic [CNT_W-1:0]  pop_len;
  logic              run_done;

  assign pop_cmd = q_head[CMD_W-1:0];
  assign pop_len = q_head[Q_W-1:CMD_W];

  sfd_front #(
    .BUFFER_BYTES (BUFFER_BYTES)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .action    (action),
    .rx_byte   (rx_byte),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .wr_data   (wr_data),
    .q_push    (q_push),
    .q_cmd     (push_cmd),
    .q_len     (push_len),
    .q_ready   (q_ready),
    .run_done  (run_done)
  );

  sfd_fifo #(
    .WIDTH (Q_W),
    .DEPTH (2)
  ) u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data ({push_len, push_cmd}),
    .ready     (q_ready),
    .valid     (q_valid),
    .pop       (q_pop),
    .pop_data  (q_head)
  );

  sfd_back #(
    .BUFFER_BYTES (BUFFER_BYTES)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .wr_en        (wr_en),
    .wr_addr      (wr_addr),
    .wr_data      (wr_data),
    .q_valid      (q_valid),
    .q_cmd        (pop_cmd),
    .q_len        (pop_len),
    .q_pop        (q_pop),
    .run_done     (run_done),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .kind         (kind),
    .payload_byte (payload_byte),
    .last         (last),
    .frame_length (frame_length)
  );

endmodule

// File: src/sfd_checker.sv
// ----------------------------------------------------------------------------
// Deframer port checker
// Watches the result channel of the deframer over time; bound to the top.
// ----------------------------------------------------------------------------
`include "serial_frame_deframer_sum16_macros.svh"

module sfd_checker
  import sfd_pkg::*;
(
  input logic            clk,
  input logic            rst,
  input logic            out_valid,
  input logic            out_stall,
  input logic [2:0]      kind,
  input logic [7:0]      payload_byte,
  input logic            last,
  input logic [FL_W-1:0] frame_length
);

  // stalled result holds
  `SFD_ASSERT_NEXT(a_hold, clk, rst, out_valid && out_stall,
    out_valid && $stable(kind) && $stable(payload_byte) && $stable(last) && $stable(frame_length),
    "result changed while stalled")

  // single-result kinds close their run
  `SFD_ASSERT_SAME(a_single_last, clk, rst, out_valid && (kind != KIND_BYTE), last,
    "single result without last")

  // empty, timeout and overflow results report no payload
  `SFD_ASSERT_SAME(a_zero_len, clk, rst,
    out_valid && (kind == KIND_EMPTY || kind == KIND_TIMEOUT || kind == KIND_OVERFLOW),
    frame_length == '0 && payload_byte == 8'h00, "nonzero length on empty result")

  // a run continues with the next byte after a frame store read
  `SFD_ASSERT_NEXT(a_run_next, clk, rst,
    out_valid && !out_stall && kind == KIND_BYTE && !last,
    !out_valid ##1 (out_valid && kind == KIND_BYTE && frame_length == $past(frame_length, 2)),
    "payload run broken")

endmodule

bind serial_frame_deframer_sum16 sfd_checker u_sfd_checker (
  .clk          (clk),
  .rst          (rst),
  .out_valid    (out_valid),
  .out_stall    (out_stall),
  .kind         (kind),
  .payload_byte (payload_byte),
  .last         (last),
  .frame_length (frame_length)
);
